FILE: rtl/command_line_tokenizer_core_defines.svh
// Assertion macros shared by the command line tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CLT_NEVER(lbl, cond, msg) \
  `CLT_ASSERT(lbl, !(cond), msg)
`else
`define CLT_ASSERT(lbl, prop, msg)
`define CLT_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/clt_pkg.sv
// Types, constants and helpers of the command line tokenizer.
package clt_pkg;

  localparam int MAX_ARGS    = 16;
  localparam int ARG_CNT_W   = $clog2(MAX_ARGS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int MAX_RES     = 3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_END    = 2'd1,
    KIND_ACCEPT = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  // ROLE_ARG doubles as "no target pending" for the wanted target.
  typedef enum logic [1:0] {
    ROLE_ARG = 2'd0,
    ROLE_IN  = 2'd1,
    ROLE_OUT = 2'd2,
    ROLE_ERR = 2'd3
  } role_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  text_byte;
    role_e       role;
    logic        append;
    logic [3:0]  arg_index;
  } res_t;

  // All results caused by one input byte, oldest in entry 0.
  typedef struct packed {
    logic [1:0]            cnt;
    res_t [MAX_RES-1:0]    r;
  } bundle_t;

  function automatic res_t mk_res(kind_e kind, logic [7:0] text_byte, role_e role,
                                  logic append, logic [3:0] arg_index);
    res_t o;
    o.kind      = kind;
    o.text_byte = text_byte;
    o.role      = role;
    o.append    = append;
    o.arg_index = arg_index;
    return o;
  endfunction

  function automatic bundle_t push_res(bundle_t b, res_t x);
    bundle_t o;
    o          = b;
    o.r[b.cnt] = x;
    o.cnt      = b.cnt + 2'd1;
    return o;
  endfunction

endpackage

FILE: rtl/clt_front.sv
// Front end: classify each byte, update line state, bundle its results.
`include "command_line_tokenizer_core_defines.svh"
module clt_front import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] ch_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  typedef struct packed {
    logic                 in_word;
    logic                 escape_pending;
    logic                 held_two;
    logic                 gt_pending;
    role_e                want_target;
    role_e                cur_role;
    logic [1:0]           append_flags;
    logic [ARG_CNT_W-1:0] arg_count;
    logic                 failed;
  } st_t;

  typedef enum logic [1:0] {
    EW_FAIL   = 2'd0,
    EW_NONE   = 2'd1,
    EW_CLOSED = 2'd2
  } ew_e;

  localparam logic [ARG_CNT_W-1:0] MAX_ARGS_C = ARG_CNT_W'(MAX_ARGS);

  st_t     st_q, st_d;
  bundle_t res_b;

  function automatic res_t word_res(kind_e kind, logic [7:0] byte_v, st_t s);
    logic       app;
    logic [3:0] idx;
    logic [6:0] wide;
    app  = 1'b0;
    idx  = 4'd0;
    wide = 7'(s.arg_count);
    if (s.cur_role == ROLE_OUT) begin
      app = s.append_flags[0];
    end else if (s.cur_role == ROLE_ERR) begin
      app = s.append_flags[1];
    end else if (s.cur_role == ROLE_ARG && wide != 7'd0) begin
      idx = 4'(wide - 7'd1);
    end
    return mk_res(kind, byte_v, s.cur_role, app, idx);
  endfunction

  always_comb begin
    st_t     g, sw_s, rej_s, ew_s, lit_s, s;
    bundle_t ew_b, lit_b, b, none_b;
    res_t    rej_r, acc_r;
    logic    sw_ok;
    ew_e     ew_rc;

    none_b = '0;
    rej_r  = mk_res(KIND_REJECT, 8'h00, ROLE_ARG, 1'b0, 4'd0);
    acc_r  = mk_res(KIND_ACCEPT, 8'h00, ROLE_ARG, 1'b0, 4'd0);

    // Working copy with the one-byte look-ahead flags dropped.
    g                = st_q;
    g.gt_pending     = 1'b0;
    g.escape_pending = 1'b0;

    rej_s        = g;
    rej_s.failed = 1'b1;

    // Opening a word: take the pending target, else count an argument.
    sw_ok          = (g.want_target != ROLE_ARG) || (g.arg_count < MAX_ARGS_C);
    sw_s           = g;
    sw_s.in_word   = 1'b1;
    sw_s.held_two  = 1'b0;
    if (g.want_target != ROLE_ARG) begin
      sw_s.cur_role    = g.want_target;
      sw_s.want_target = ROLE_ARG;
    end else begin
      sw_s.arg_count = g.arg_count + ARG_CNT_W'(1);
      sw_s.cur_role  = ROLE_ARG;
    end

    // Close the open word, releasing a held '2' first.
    if (g.held_two) begin
      if (!sw_ok) begin
        ew_rc = EW_FAIL;
        ew_s  = rej_s;
        ew_b  = push_res(none_b, rej_r);
      end else begin
        ew_rc        = EW_CLOSED;
        ew_s         = sw_s;
        ew_s.in_word = 1'b0;
        ew_b         = push_res(push_res(none_b, word_res(KIND_BYTE, CH_TWO, sw_s)),
                                word_res(KIND_END, 8'h00, sw_s));
      end
    end else if (!g.in_word) begin
      ew_rc = EW_NONE;
      ew_s  = g;
      ew_b  = none_b;
    end else begin
      ew_rc        = EW_CLOSED;
      ew_s         = g;
      ew_s.in_word = 1'b0;
      ew_b         = push_res(none_b, word_res(KIND_END, 8'h00, g));
    end

    // Ordinary word byte.
    if (g.held_two) begin
      if (!sw_ok) begin
        lit_s = rej_s;
        lit_b = push_res(none_b, rej_r);
      end else begin
        lit_s = sw_s;
        lit_b = push_res(push_res(none_b, word_res(KIND_BYTE, CH_TWO, sw_s)),
                         word_res(KIND_BYTE, ch_i, sw_s));
      end
    end else if (!g.in_word) begin
      if (ch_i == CH_TWO) begin
        lit_s          = g;
        lit_s.in_word  = 1'b1;
        lit_s.held_two = 1'b1;
        lit_b          = none_b;
      end else if (!sw_ok) begin
        lit_s = rej_s;
        lit_b = push_res(none_b, rej_r);
      end else begin
        lit_s = sw_s;
        lit_b = push_res(none_b, word_res(KIND_BYTE, ch_i, sw_s));
      end
    end else begin
      lit_s = g;
      lit_b = push_res(none_b, word_res(KIND_BYTE, ch_i, g));
    end

    s = st_q;
    b = none_b;
    if (st_q.failed) begin
      s = st_q;
    end else if (st_q.escape_pending) begin
      if (ch_i == CH_NUL) begin
        s = rej_s;
        b = push_res(none_b, rej_r);
      end else begin
        s = lit_s;
        b = lit_b;
      end
    end else if (st_q.gt_pending && ch_i == CH_GT) begin
      s              = g;
      s.append_flags = g.append_flags |
                       ((g.want_target == ROLE_ERR) ? 2'b10 : 2'b01);
    end else begin
      unique case (ch_i)
        CH_NUL: begin
          s = ew_s;
          if (ew_rc == EW_FAIL) begin
            b = ew_b;
          end else begin
            b = push_res(ew_b, (ew_s.want_target != ROLE_ARG) ? rej_r : acc_r);
          end
        end
        CH_SPACE: begin
          s = ew_s;
          b = ew_b;
        end
        CH_LT, CH_GT: begin
          if (ch_i == CH_GT && g.held_two) begin
            if (g.want_target != ROLE_ARG) begin
              s = rej_s;
              b = push_res(none_b, rej_r);
            end else begin
              s              = g;
              s.held_two     = 1'b0;
              s.in_word      = 1'b0;
              s.want_target  = ROLE_ERR;
              s.append_flags = g.append_flags & 2'b01;
              s.gt_pending   = 1'b1;
            end
          end else if (ew_rc == EW_FAIL) begin
            s = ew_s;
            b = ew_b;
          end else if (ew_rc == EW_NONE && g.want_target != ROLE_ARG) begin
            s = rej_s;
            b = push_res(none_b, rej_r);
          end else begin
            s = ew_s;
            b = ew_b;
            if (ch_i == CH_LT) begin
              s.want_target = ROLE_IN;
            end else begin
              s.want_target  = ROLE_OUT;
              s.append_flags = ew_s.append_flags & 2'b10;
              s.gt_pending   = 1'b1;
            end
          end
        end
        CH_PIPE, CH_DOLLAR: begin
          s = rej_s;
          b = push_res(none_b, rej_r);
        end
        CH_BSLASH: begin
          if (g.held_two && !sw_ok) begin
            s = rej_s;
            b = push_res(none_b, rej_r);
          end else if (g.held_two) begin
            s                = sw_s;
            s.escape_pending = 1'b1;
            b                = push_res(none_b, word_res(KIND_BYTE, CH_TWO, sw_s));
          end else begin
            s                = g;
            s.escape_pending = 1'b1;
          end
        end
        default: begin
          s = lit_s;
          b = lit_b;
        end
      endcase
    end

    if (ch_i == CH_NUL) begin
      s = '0;
    end

    st_d  = acc_i ? s : st_q;
    res_b = b;
  end

  assign push_o   = acc_i && (res_b.cnt != 2'd0);
  assign bundle_o = res_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  `CLT_ASSERT(a_line_clear, (acc_i && ch_i == CH_NUL) |=> (st_q == '0), "line state not cleared")
  `CLT_NEVER(a_swallow, acc_i && st_q.failed && push_o, "result after rejection")

endmodule

FILE: rtl/clt_queue.sv
// Short bundle queue between the front end and the result serialiser.
`include "command_line_tokenizer_core_defines.svh"
module clt_queue import clt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    head_valid_o,
  output bundle_t head_o
);

  bundle_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  `CLT_NEVER(a_pop_empty, pop_i && cnt_q == '0, "pop from empty queue")
  `CLT_ASSERT(a_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)), "count lost")

endmodule

FILE: rtl/clt_back.sv
// Back end: hand out the results of the head bundle one transfer at a time.
`include "command_line_tokenizer_core_defines.svh"
module clt_back import clt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  bundle_t     head_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic [1:0] idx_q;
  res_t       cur;
  logic       last;
  logic       xfer;

  assign cur  = head_i.r[idx_q];
  assign last = (idx_q == head_i.cnt - 2'd1);
  assign xfer = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = head_valid_i;
  assign m_axis_tdata  = {1'b0, cur.arg_index, cur.append, cur.role, cur.text_byte};
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = last;
  assign pop_o         = xfer && last;

  // Advance through the bundle; restart at its first entry once it is popped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

  `CLT_NEVER(a_idx_range, head_valid_i && (idx_q >= head_i.cnt), "index beyond bundle")

endmodule

FILE: rtl/command_line_tokenizer_core.sv
// Top level of the command line tokenizer core.
//
// Takes one command line byte per transfer on the slave stream (a zero byte
// ends the line) and produces a stream of tokens: each word byte tagged with
// its role (argument, input, output or error file target), a word-end token
// after each word, and one accepted or rejected token per line. A byte is
// accepted in every cycle while the four-entry result queue has room; the
// byte is classified and all its results (up to three) are formed in the
// cycle it is accepted, then the back end hands them out at one transfer per
// cycle while the output is ready. A byte causes zero to three results;
// sustained throughput is set by the output port, one result per cycle
// when it is not stalled. After a rejection the rest of the line,
// up to and including its zero byte, is swallowed with no results. tlast
// marks the final result caused by one input byte.
module command_line_tokenizer_core import clt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] text_byte, [9:8] role, [10] append,
                                      // [14:11] arg_index, [15] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic    acc;
  logic    push;
  logic    pop;
  logic    full;
  logic    head_valid;
  bundle_t push_bundle;
  bundle_t head;

  // Hold off input only while the queue is full; output stalls never reach
  // the input combinationally.
  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  clt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .ch_i     (s_axis_tdata),
    .push_o   (push),
    .bundle_o (push_bundle)
  );

  clt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (push_bundle),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  clt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
